FILE: rtl/crc_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkg: shared types and constants for the color ratio classifier
// Holds the class codes, register indexes, register reset values, the
// threshold register struct and the control tag passed through the divider cells to the output stage.
// ----------------------------------------------------------------------------
package crc_pkg;

  // Color class codes
  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_YELLOW  = 3'd1;
  localparam logic [2:0] CLS_GREEN   = 3'd2;
  localparam logic [2:0] CLS_BLUE    = 3'd3;
  localparam logic [2:0] CLS_RED     = 3'd4;

  // Output field and register widths
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned RATIO_W = 23;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [RATIO_W-1:0] RATIO_MAX = 23'd8388607;
  localparam logic [6:0]         RATIO_SCALE = 7'd100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RB_UPPER  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RB_LOWER  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RG_UPPER  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RG_LOWER  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RG_SPLIT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RB_YELLOW = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RB_GREEN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RB_RED    = 4'd7;

  // Register reset values
  localparam logic [THR_W-1:0] RST_RB_UPPER  = 16'd300;
  localparam logic [THR_W-1:0] RST_RB_LOWER  = 16'd60;
  localparam logic [THR_W-1:0] RST_RG_UPPER  = 16'd600;
  localparam logic [THR_W-1:0] RST_RG_LOWER  = 16'd250;
  localparam logic [THR_W-1:0] RST_RG_SPLIT  = 16'd325;
  localparam logic [THR_W-1:0] RST_RB_YELLOW = 16'd170;
  localparam logic [THR_W-1:0] RST_RB_GREEN  = 16'd140;
  localparam logic [THR_W-1:0] RST_RB_RED    = 16'd160;

  // Threshold register set
  typedef struct packed {
    logic [THR_W-1:0] rb_upper_limit;
    logic [THR_W-1:0] rb_lower_limit;
    logic [THR_W-1:0] rg_upper_limit;
    logic [THR_W-1:0] rg_lower_limit;
    logic [THR_W-1:0] rg_split;
    logic [THR_W-1:0] rb_yellow_min;
    logic [THR_W-1:0] rb_green_min;
    logic [THR_W-1:0] rb_red_min;
  } crc_cfg_t;

  // Control tag that travels with each transaction down the chain
  typedef struct packed {
    logic valid;
    logic rg_zero;
    logic rb_zero;
  } crc_tag_t;

endpackage

FILE: rtl/crc_div_cell.sv
// ----------------------------------------------------------------------------
// crc_div_cell: one restoring division step for both ratios
// Each cell resolves one quotient bit of red*100/green and red*100/blue and
// hands the partial remainder, the dividend/quotient word and the divisors
// to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module crc_div_cell #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crc_pkg::crc_tag_t      tag_i,
  input  logic [COUNT_BITS+6:0]  rg_dq_i,
  input  logic [COUNT_BITS-1:0]  rg_rem_i,
  input  logic [COUNT_BITS-1:0]  g_i,
  input  logic [COUNT_BITS+6:0]  rb_dq_i,
  input  logic [COUNT_BITS-1:0]  rb_rem_i,
  input  logic [COUNT_BITS-1:0]  b_i,
  output crc_pkg::crc_tag_t      tag_o,
  output logic [COUNT_BITS+6:0]  rg_dq_o,
  output logic [COUNT_BITS-1:0]  rg_rem_o,
  output logic [COUNT_BITS-1:0]  g_o,
  output logic [COUNT_BITS+6:0]  rb_dq_o,
  output logic [COUNT_BITS-1:0]  rb_rem_o,
  output logic [COUNT_BITS-1:0]  b_o
);
  import crc_pkg::*;

  localparam int unsigned NW = COUNT_BITS + 7;

  logic [COUNT_BITS:0]   rg_part, rg_diff, rb_part, rb_diff;
  logic                  rg_ge, rb_ge;
  crc_tag_t              tag_r;
  logic [NW-1:0]         rg_dq_r, rb_dq_r, rg_dq_nxt, rb_dq_nxt;
  logic [COUNT_BITS-1:0] rg_rem_r, rb_rem_r, rg_rem_nxt, rb_rem_nxt;
  logic [COUNT_BITS-1:0] g_r, b_r;

  // Shift in next dividend bit, trial subtract, restore on borrow
  always_comb begin
    rg_part    = {rg_rem_i, rg_dq_i[NW-1]};
    rg_ge      = (rg_part >= {1'b0, g_i});
    rg_diff    = rg_part - {1'b0, g_i};
    rg_rem_nxt = rg_ge ? rg_diff[COUNT_BITS-1:0] : rg_part[COUNT_BITS-1:0];
    rg_dq_nxt  = {rg_dq_i[NW-2:0], rg_ge};

    rb_part    = {rb_rem_i, rb_dq_i[NW-1]};
    rb_ge      = (rb_part >= {1'b0, b_i});
    rb_diff    = rb_part - {1'b0, b_i};
    rb_rem_nxt = rb_ge ? rb_diff[COUNT_BITS-1:0] : rb_part[COUNT_BITS-1:0];
    rb_dq_nxt  = {rb_dq_i[NW-2:0], rb_ge};
  end

  // Control tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rg_dq_r  <= rg_dq_nxt;
    rg_rem_r <= rg_rem_nxt;
    g_r      <= g_i;
    rb_dq_r  <= rb_dq_nxt;
    rb_rem_r <= rb_rem_nxt;
    b_r      <= b_i;
  end

  assign tag_o    = tag_r;
  assign rg_dq_o  = rg_dq_r;
  assign rg_rem_o = rg_rem_r;
  assign g_o      = g_r;
  assign rb_dq_o  = rb_dq_r;
  assign rb_rem_o = rb_rem_r;
  assign b_o      = b_r;

endmodule

FILE: rtl/crc_classify.sv
// ----------------------------------------------------------------------------
// crc_classify: ratio saturation, window checks and color decision
// Takes the finished quotients from the end of the divider chain, compares
// the exact ratios against the thresholds and registers the result.
// ----------------------------------------------------------------------------
module crc_classify #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crc_pkg::crc_tag_t             tag_i,
  input  logic [COUNT_BITS+6:0]         rg_q_i,
  input  logic [COUNT_BITS+6:0]         rb_q_i,
  input  crc_pkg::crc_cfg_t             cfg_i,
  output logic                          out_valid,
  output logic [crc_pkg::CLASS_W-1:0]   out_color_class,
  output logic [crc_pkg::RATIO_W-1:0]   out_rg_ratio,
  output logic [crc_pkg::RATIO_W-1:0]   out_rb_ratio,
  output logic                          out_zero_divisor
);
  import crc_pkg::*;

  localparam int unsigned NW = COUNT_BITS + 7;
  localparam int unsigned CW = (NW > RATIO_W) ? NW : RATIO_W;

  logic [CW-1:0]      rg_ext, rb_ext;
  logic               zero;
  logic               outside;
  logic [CLASS_W-1:0] cls_nxt;
  logic [RATIO_W-1:0] rg_nxt, rb_nxt;

  logic               valid_r;
  logic [CLASS_W-1:0] cls_r;
  logic [RATIO_W-1:0] rg_r, rb_r;
  logic               zero_r;

  // Saturated ratios and class decision on exact quotients
  always_comb begin
    rg_ext  = CW'(rg_q_i);
    rb_ext  = CW'(rb_q_i);
    zero    = tag_i.rg_zero | tag_i.rb_zero;
    outside = (rb_ext > CW'(cfg_i.rb_upper_limit)) ||
              (rb_ext < CW'(cfg_i.rb_lower_limit)) ||
              (rg_ext > CW'(cfg_i.rg_upper_limit)) ||
              (rg_ext < CW'(cfg_i.rg_lower_limit));

    priority if (zero || outside) begin
      cls_nxt = CLS_UNKNOWN;
    end else if (rg_ext < CW'(cfg_i.rg_split)) begin
      priority if (rb_ext > CW'(cfg_i.rb_yellow_min)) begin
        cls_nxt = CLS_YELLOW;
      end else if (rb_ext > CW'(cfg_i.rb_green_min)) begin
        cls_nxt = CLS_GREEN;
      end else begin
        cls_nxt = CLS_BLUE;
      end
    end else if (rb_ext > CW'(cfg_i.rb_red_min)) begin
      cls_nxt = CLS_RED;
    end else begin
      cls_nxt = CLS_UNKNOWN;
    end

    if (tag_i.rg_zero) begin
      rg_nxt = '0;
    end else if (rg_ext > CW'(RATIO_MAX)) begin
      rg_nxt = RATIO_MAX;
    end else begin
      rg_nxt = rg_ext[RATIO_W-1:0];
    end

    if (tag_i.rb_zero) begin
      rb_nxt = '0;
    end else if (rb_ext > CW'(RATIO_MAX)) begin
      rb_nxt = RATIO_MAX;
    end else begin
      rb_nxt = rb_ext[RATIO_W-1:0];
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tag_i.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    cls_r  <= cls_nxt;
    rg_r   <= rg_nxt;
    rb_r   <= rb_nxt;
    zero_r <= zero;
  end

  assign out_valid        = valid_r;
  assign out_color_class  = cls_r;
  assign out_rg_ratio     = rg_r;
  assign out_rb_ratio     = rb_r;
  assign out_zero_divisor = zero_r;

endmodule

FILE: rtl/color_ratio_classifier.sv
// ----------------------------------------------------------------------------
// color_ratio_classifier: color class from red/green/blue sensor counts
// Forms red*100/green and red*100/blue in a row of division cells and
// classifies the color against eight threshold registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken when start is high and busy is low. busy
//   is high only in the cycle after reset and low otherwise, so a new count
//   set can be issued in every cycle.
//   Output: each transaction gives one result, shown for one cycle with
//   out_valid high. The receiver cannot stall; results come in issue order.
//   Pipeline: the multiply by 100 is registered, then there is one division
//   cell per quotient bit (COUNT_BITS + 7 cells), then the classification is
//   registered. Throughput is one transaction per cycle while busy is low,
//   set by the chain of cells.
//   Configuration: cfg_ready is always high; a write to index 0..7 updates
//   that threshold, other indexes are ignored. Write only while idle.
//   Reset: synchronous, active low; thresholds return to their defaults and
//   any transaction in flight is dropped.
// ----------------------------------------------------------------------------
module color_ratio_classifier #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            start,
  output logic                            busy,
  input  logic [COUNT_BITS-1:0]           in_red_count,
  input  logic [COUNT_BITS-1:0]           in_green_count,
  input  logic [COUNT_BITS-1:0]           in_blue_count,
  // Result channel
  output logic                            out_valid,
  output logic [crc_pkg::CLASS_W-1:0]     out_color_class,
  output logic [crc_pkg::RATIO_W-1:0]     out_rg_ratio,
  output logic [crc_pkg::RATIO_W-1:0]     out_rb_ratio,
  output logic                            out_zero_divisor,
  // Configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crc_pkg::THR_W-1:0]       cfg_data
);
  import crc_pkg::*;

  localparam int unsigned NW = COUNT_BITS + 7;

  logic     busy_r;
  logic     accept;
  crc_cfg_t cfg_r;

  // Chain taps: index 0 is the multiply stage, index NW the last cell
  crc_tag_t              tag_s    [0:NW];
  logic [NW-1:0]         rg_dq_s  [0:NW];
  logic [NW-1:0]         rb_dq_s  [0:NW];
  logic [COUNT_BITS-1:0] rg_rem_s [0:NW];
  logic [COUNT_BITS-1:0] rb_rem_s [0:NW];
  logic [COUNT_BITS-1:0] g_s      [0:NW];
  logic [COUNT_BITS-1:0] b_s      [0:NW];

  crc_tag_t              tag0_r;
  logic [NW-1:0]         num_r;
  logic [COUNT_BITS-1:0] g0_r, b0_r;

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Hold off the first cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rb_upper_limit <= RST_RB_UPPER;
      cfg_r.rb_lower_limit <= RST_RB_LOWER;
      cfg_r.rg_upper_limit <= RST_RG_UPPER;
      cfg_r.rg_lower_limit <= RST_RG_LOWER;
      cfg_r.rg_split       <= RST_RG_SPLIT;
      cfg_r.rb_yellow_min  <= RST_RB_YELLOW;
      cfg_r.rb_green_min   <= RST_RB_GREEN;
      cfg_r.rb_red_min     <= RST_RB_RED;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RB_UPPER:  cfg_r.rb_upper_limit <= cfg_data;
        REG_RB_LOWER:  cfg_r.rb_lower_limit <= cfg_data;
        REG_RG_UPPER:  cfg_r.rg_upper_limit <= cfg_data;
        REG_RG_LOWER:  cfg_r.rg_lower_limit <= cfg_data;
        REG_RG_SPLIT:  cfg_r.rg_split       <= cfg_data;
        REG_RB_YELLOW: cfg_r.rb_yellow_min  <= cfg_data;
        REG_RB_GREEN:  cfg_r.rb_green_min   <= cfg_data;
        REG_RB_RED:    cfg_r.rb_red_min     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Multiply stage: control tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else begin
      tag0_r.valid   <= accept;
      tag0_r.rg_zero <= (in_green_count == '0);
      tag0_r.rb_zero <= (in_blue_count == '0);
    end
  end

  // Multiply stage: red * 100 and divisors
  always_ff @(posedge clk) begin
    num_r <= NW'(in_red_count) * NW'(RATIO_SCALE);
    g0_r  <= in_green_count;
    b0_r  <= in_blue_count;
  end

  assign tag_s[0]    = tag0_r;
  assign rg_dq_s[0]  = num_r;
  assign rb_dq_s[0]  = num_r;
  assign rg_rem_s[0] = '0;
  assign rb_rem_s[0] = '0;
  assign g_s[0]      = g0_r;
  assign b_s[0]      = b0_r;

  // Division chain: one cell per quotient bit, MSB first
  for (genvar i = 0; i < NW; i++) begin : g_cell
    crc_div_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tag_i    (tag_s[i]),
      .rg_dq_i  (rg_dq_s[i]),
      .rg_rem_i (rg_rem_s[i]),
      .g_i      (g_s[i]),
      .rb_dq_i  (rb_dq_s[i]),
      .rb_rem_i (rb_rem_s[i]),
      .b_i      (b_s[i]),
      .tag_o    (tag_s[i+1]),
      .rg_dq_o  (rg_dq_s[i+1]),
      .rg_rem_o (rg_rem_s[i+1]),
      .g_o      (g_s[i+1]),
      .rb_dq_o  (rb_dq_s[i+1]),
      .rb_rem_o (rb_rem_s[i+1]),
      .b_o      (b_s[i+1])
    );
  end

  // Output stage
  crc_classify #(
    .COUNT_BITS (COUNT_BITS)
  ) u_classify (
    .clk              (clk),
    .rst_n            (rst_n),
    .tag_i            (tag_s[NW]),
    .rg_q_i           (rg_dq_s[NW]),
    .rb_q_i           (rb_dq_s[NW]),
    .cfg_i            (cfg_r),
    .out_valid        (out_valid),
    .out_color_class  (out_color_class),
    .out_rg_ratio     (out_rg_ratio),
    .out_rb_ratio     (out_rb_ratio),
    .out_zero_divisor (out_zero_divisor)
  );

endmodule
